// ===== hw/rtl/rlfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Ranked-list file statistics parser package
// Shared character codes, parser phases, the event that the front part
// hands to the back part, and the saturating decimal digit step.
// ----------------------------------------------------------------------------
package rlfs_pkg;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_UPPER_L = 8'd76;

    localparam int QCOUNT_W = 20;
    localparam logic [QCOUNT_W-1:0] QCOUNT_MAX = 20'hFFFFF;
    localparam int VAL_W = 16;
    localparam int VCOUNT_W = 8;

    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = 8'hFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [1:0] {
        PH_REL  = 2'd0,
        PH_QID  = 2'd1,
        PH_VOT  = 2'd2,
        PH_SKIP = 2'd3
    } phase_t;

    typedef enum logic {
        BK_CLEAR = 1'b0,
        BK_RUN   = 1'b1
    } back_state_t;

    typedef struct packed {
        logic                tok;
        logic [VAL_W-1:0]    voter;
        logic [VAL_W-1:0]    rank;
        logic                last;
        logic [QCOUNT_W-1:0] qcount;
    } event_t;

    function automatic logic [VAL_W-1:0] dec_sat16(logic [VAL_W-1:0] acc, logic [3:0] dig);
        logic [19:0] wide;
        logic [19:0] val;
        wide = {4'd0, acc};
        val = (wide << 3) + (wide << 1) + {16'd0, dig};
        return (val > 20'd65535) ? 16'hFFFF : val[VAL_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/rlfs_if.sv =====
// ----------------------------------------------------------------------------
// Ranked-list file statistics parser channels
// Valid/ready channels for text bytes in and statistics out.
// ----------------------------------------------------------------------------
interface rlfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface rlfs_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] query_count;
    logic [7:0]  voter_count;
    logic [15:0] max_rank;

    modport source (output valid, output query_count, output voter_count, output max_rank,
                    input ready);
    modport sink (input valid, input query_count, input voter_count, input max_rank,
                  output ready);
endinterface

// ===== hw/rtl/rlfs_front.sv =====
// ----------------------------------------------------------------------------
// Ranked-list file statistics parser front end
// Parses one byte per cycle while the event queue has room, tracks query runs and builds voter tokens.
// Finished tokens and the end of the text leave as events.
// ----------------------------------------------------------------------------
module rlfs_front #(
    parameter int TOPIC_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    rlfs_in_if.sink             in_ch,
    input  logic                ev_full,
    output logic                ev_push,
    output rlfs_pkg::event_t    ev
);

    rlfs_pkg::phase_t            phase_reg, phase_next;
    logic                        colon_reg, colon_next;
    logic [TOPIC_BITS-1:0]       topic_reg, topic_next;
    logic [TOPIC_BITS-1:0]       prev_reg, prev_next;
    logic [rlfs_pkg::QCOUNT_W-1:0] qcnt_reg, qcnt_next;
    logic [rlfs_pkg::VAL_W-1:0]  voter_reg, voter_next;
    logic [rlfs_pkg::VAL_W-1:0]  rank_reg, rank_next;
    logic                        nonempty_reg, nonempty_next;
    logic                        last_l_reg, last_l_next;

    logic       accept;
    logic       sep;
    logic       is_dig;
    logic [7:0] b;
    logic [3:0] dig;

    assign in_ch.ready = !ev_full;
    assign accept = in_ch.valid && in_ch.ready;
    assign b = in_ch.data_byte;
    assign dig = b[3:0];
    assign sep = (b == rlfs_pkg::CH_TAB) || (b == rlfs_pkg::CH_SPACE);
    assign is_dig = b inside {[rlfs_pkg::CH_ZERO:rlfs_pkg::CH_NINE]};

    always_comb
    begin
        phase_next = phase_reg;
        colon_next = colon_reg;
        topic_next = topic_reg;
        prev_next = prev_reg;
        qcnt_next = qcnt_reg;
        voter_next = voter_reg;
        rank_next = rank_reg;
        nonempty_next = nonempty_reg;
        last_l_next = last_l_reg;
        ev = '0;
        ev_push = 1'b0;
        if (accept)
        begin
            if (b == rlfs_pkg::CH_LF)
            begin
                if (qcnt_next != '0 && topic_next != prev_next)
                begin
                    if (qcnt_next != rlfs_pkg::QCOUNT_MAX)
                    begin
                        qcnt_next = qcnt_next + 1'b1;
                    end
                    prev_next = topic_next;
                end
                colon_next = 1'b0;
                voter_next = '0;
                rank_next = '0;
                nonempty_next = 1'b0;
                last_l_next = 1'b0;
                phase_next = rlfs_pkg::PH_REL;
            end
            else
            begin
                case (phase_reg)
                    rlfs_pkg::PH_REL:
                    begin
                        if (sep)
                        begin
                            phase_next = rlfs_pkg::PH_QID;
                            topic_next = '0;
                            colon_next = 1'b0;
                        end
                    end
                    rlfs_pkg::PH_QID:
                    begin
                        if (sep)
                        begin
                            phase_next = rlfs_pkg::PH_VOT;
                            colon_next = 1'b0;
                            voter_next = '0;
                            rank_next = '0;
                            nonempty_next = 1'b0;
                            last_l_next = 1'b0;
                            if (qcnt_reg == '0)
                            begin
                                prev_next = topic_reg;
                                qcnt_next = {{(rlfs_pkg::QCOUNT_W-1){1'b0}}, 1'b1};
                            end
                        end
                        else if (b == rlfs_pkg::CH_COLON)
                        begin
                            topic_next = '0;
                            colon_next = 1'b1;
                        end
                        else if (colon_reg)
                        begin
                            if (is_dig)
                            begin
                                topic_next = (topic_reg << 3) + (topic_reg << 1)
                                           + TOPIC_BITS'(dig);
                            end
                            else
                            begin
                                colon_next = 1'b0;
                            end
                        end
                    end
                    rlfs_pkg::PH_VOT:
                    begin
                        if (b == rlfs_pkg::CH_HASH || b == rlfs_pkg::CH_SPACE)
                        begin
                            ev.tok = nonempty_reg && !last_l_reg;
                            ev.voter = voter_reg;
                            ev.rank = rank_reg;
                            colon_next = 1'b0;
                            voter_next = '0;
                            rank_next = '0;
                            nonempty_next = 1'b0;
                            last_l_next = 1'b0;
                            if (b == rlfs_pkg::CH_HASH)
                            begin
                                phase_next = rlfs_pkg::PH_SKIP;
                            end
                        end
                        else
                        begin
                            nonempty_next = 1'b1;
                            last_l_next = (b == rlfs_pkg::CH_UPPER_L);
                            if (b == rlfs_pkg::CH_COLON)
                            begin
                                if (!colon_reg)
                                begin
                                    colon_next = 1'b1;
                                end
                                else
                                begin
                                    rank_next = '0;
                                end
                            end
                            else if (is_dig)
                            begin
                                if (colon_reg)
                                begin
                                    rank_next = rlfs_pkg::dec_sat16(rank_reg, dig);
                                end
                                else
                                begin
                                    voter_next = rlfs_pkg::dec_sat16(voter_reg, dig);
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (in_ch.end_of_input)
            begin
                if (qcnt_next != '0 && topic_next != prev_next)
                begin
                    if (qcnt_next != rlfs_pkg::QCOUNT_MAX)
                    begin
                        qcnt_next = qcnt_next + 1'b1;
                    end
                end
                ev.last = 1'b1;
                ev.qcount = qcnt_next;
                phase_next = rlfs_pkg::PH_REL;
                colon_next = 1'b0;
                topic_next = '0;
                prev_next = '0;
                qcnt_next = '0;
                voter_next = '0;
                rank_next = '0;
                nonempty_next = 1'b0;
                last_l_next = 1'b0;
            end
            ev_push = ev.tok || ev.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rlfs_pkg::PH_REL;
            colon_reg <= 1'b0;
            topic_reg <= '0;
            prev_reg <= '0;
            qcnt_reg <= '0;
            voter_reg <= '0;
            rank_reg <= '0;
            nonempty_reg <= 1'b0;
            last_l_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            colon_reg <= colon_next;
            topic_reg <= topic_next;
            prev_reg <= prev_next;
            qcnt_reg <= qcnt_next;
            voter_reg <= voter_next;
            rank_reg <= rank_next;
            nonempty_reg <= nonempty_next;
            last_l_reg <= last_l_next;
        end
    end

endmodule

// ===== hw/rtl/rlfs_fifo.sv =====
// ----------------------------------------------------------------------------
// Ranked-list file statistics parser event queue
// Short first-in first-out queue of events between front and back parts.
// ----------------------------------------------------------------------------
module rlfs_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rlfs_pkg::event_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output rlfs_pkg::event_t pop_data
);

    rlfs_pkg::event_t                  store_reg [rlfs_pkg::FIFO_DEPTH];
    logic [rlfs_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rlfs_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rlfs_pkg::FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                              do_push;
    logic                              do_pop;

    assign full = (count_reg == rlfs_pkg::FIFO_CNT_W'(rlfs_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + rlfs_pkg::FIFO_PTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + rlfs_pkg::FIFO_PTR_W'(do_pop);
        count_next = count_reg + rlfs_pkg::FIFO_CNT_W'(do_push)
                   - rlfs_pkg::FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/rlfs_back.sv =====
// ----------------------------------------------------------------------------
// Ranked-list file statistics parser back end
// Marks voters in an epoch-tagged map, tracks the largest rank and
// issues the statistics at the end of each text.
// ----------------------------------------------------------------------------
module rlfs_back #(
    parameter int MAX_VOTERS = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ev_valid,
    input  rlfs_pkg::event_t ev,
    output logic             ev_pop,
    rlfs_out_if.source       out_ch
);

    localparam int ADDR_W = (MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1;
    localparam int CNT_W = $clog2(MAX_VOTERS + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_VOTERS - 1);

    logic [rlfs_pkg::EPOCH_W-1:0] tag_mem [MAX_VOTERS];

    rlfs_pkg::back_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]            clr_addr_reg, clr_addr_next;
    logic [rlfs_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic                         s1_valid_reg, s1_valid_next;
    rlfs_pkg::event_t             s1_ev_reg;
    logic [ADDR_W-1:0]            s1_idx_reg;
    logic                         s1_inrange_reg;
    logic [rlfs_pkg::EPOCH_W-1:0] rd_tag_reg;
    logic                         hazard_reg, hazard_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [rlfs_pkg::VAL_W-1:0]   max_reg, max_next;
    logic                         out_valid_reg, out_valid_next;
    logic [rlfs_pkg::QCOUNT_W-1:0] out_q_reg;
    logic [rlfs_pkg::VCOUNT_W-1:0] out_v_reg;
    logic [rlfs_pkg::VAL_W-1:0]   out_m_reg;

    logic                         out_free;
    logic                         s1_go;
    logic                         epoch_wrap;
    logic                         new_inrange;
    logic [ADDR_W-1:0]            new_idx;
    logic                         seen;
    logic                         count_it;
    logic [CNT_W-1:0]             cnt_upd;
    logic [rlfs_pkg::VAL_W-1:0]   max_upd;
    logic [15:0]                  cnt_wide;
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_addr;
    logic [rlfs_pkg::EPOCH_W-1:0] mem_wdata;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.query_count = out_q_reg;
    assign out_ch.voter_count = out_v_reg;
    assign out_ch.max_rank = out_m_reg;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign s1_go = s1_valid_reg && (!s1_ev_reg.last || out_free);
    assign epoch_wrap = s1_go && s1_ev_reg.last && (epoch_reg == rlfs_pkg::EPOCH_LAST);
    assign ev_pop = ev_valid && (state_reg == rlfs_pkg::BK_RUN) && (!s1_valid_reg || s1_go)
                  && !epoch_wrap;
    assign new_inrange = (ev.voter != '0) && (ev.voter <= rlfs_pkg::VAL_W'(MAX_VOTERS));
    assign new_idx = ADDR_W'(ev.voter - 16'd1);

    assign seen = hazard_reg || (rd_tag_reg == epoch_reg);
    assign count_it = s1_go && s1_ev_reg.tok && s1_inrange_reg && !seen;
    assign cnt_upd = cnt_reg + CNT_W'(count_it);
    assign max_upd = (s1_go && s1_ev_reg.tok && s1_ev_reg.rank > max_reg)
                   ? s1_ev_reg.rank : max_reg;
    assign cnt_wide = 16'(cnt_upd);

    assign mem_we = (state_reg == rlfs_pkg::BK_CLEAR) || count_it;
    assign mem_addr = (state_reg == rlfs_pkg::BK_CLEAR) ? clr_addr_reg : s1_idx_reg;
    assign mem_wdata = (state_reg == rlfs_pkg::BK_CLEAR) ? '0 : epoch_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_addr_next = clr_addr_reg;
        epoch_next = epoch_reg;
        cnt_next = cnt_upd;
        max_next = max_upd;
        s1_valid_next = ev_pop || (s1_valid_reg && !s1_go);
        hazard_next = ev_pop ? (count_it && new_inrange && (new_idx == s1_idx_reg)
                                && !s1_ev_reg.last)
                             : hazard_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        case (state_reg)
            rlfs_pkg::BK_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_addr_next = '0;
                    state_next = rlfs_pkg::BK_RUN;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            rlfs_pkg::BK_RUN:
            begin
                if (s1_go && s1_ev_reg.last)
                begin
                    out_valid_next = 1'b1;
                    cnt_next = '0;
                    max_next = '0;
                    if (epoch_reg == rlfs_pkg::EPOCH_LAST)
                    begin
                        epoch_next = rlfs_pkg::EPOCH_FIRST;
                        state_next = rlfs_pkg::BK_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = rlfs_pkg::BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlfs_pkg::BK_CLEAR;
            clr_addr_reg <= '0;
            epoch_reg <= rlfs_pkg::EPOCH_FIRST;
            s1_valid_reg <= 1'b0;
            hazard_reg <= 1'b0;
            cnt_reg <= '0;
            max_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_addr_reg <= clr_addr_next;
            epoch_reg <= epoch_next;
            s1_valid_reg <= s1_valid_next;
            hazard_reg <= hazard_next;
            cnt_reg <= cnt_next;
            max_reg <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop)
        begin
            s1_ev_reg <= ev;
            s1_idx_reg <= new_idx;
            s1_inrange_reg <= new_inrange;
        end
        if (s1_go && s1_ev_reg.last)
        begin
            out_q_reg <= s1_ev_reg.qcount;
            out_v_reg <= (cnt_wide > 16'd255) ? 8'hFF : cnt_wide[7:0];
            out_m_reg <= max_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop && new_inrange)
        begin
            rd_tag_reg <= tag_mem[new_idx];
        end
        if (mem_we)
        begin
            tag_mem[mem_addr] <= mem_wdata;
        end
    end

endmodule

// ===== hw/rtl/ranked_list_file_stats_parser_core.sv =====
// Throughput: one text byte per cycle; the byte channel stalls only when the event queue is full.
// The end event of a text passes through the event queue and the back end stage register; the
// statistics item is then registered at the output. Reset clears the parser's control state,
// then the voter map is swept. The same sweep runs after every 255th text when the map epoch
// wraps; bytes are still taken while it runs, until the event queue is full.
// ----------------------------------------------------------------------------
// Ranked-list file statistics parser
// Front end parses bytes, a short queue carries token and end events, and
// the back end counts distinct voters and the largest rank.
// ----------------------------------------------------------------------------
module ranked_list_file_stats_parser_core #(
    parameter int MAX_VOTERS = 128,
    parameter int TOPIC_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    rlfs_in_if.sink    in_ch,
    rlfs_out_if.source out_ch
);

    logic             push;
    logic             full;
    logic             pop;
    logic             not_empty;
    rlfs_pkg::event_t push_ev;
    rlfs_pkg::event_t pop_ev;

    rlfs_front #(
        .TOPIC_BITS (TOPIC_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .ev_full (full),
        .ev_push (push),
        .ev      (push_ev)
    );

    rlfs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_ev),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_ev)
    );

    rlfs_back #(
        .MAX_VOTERS (MAX_VOTERS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (not_empty),
        .ev       (pop_ev),
        .ev_pop   (pop),
        .out_ch   (out_ch)
    );

endmodule

// ===== verif/ranked_list_stats_checker.sv =====
// ----------------------------------------------------------------------------
// Ranked-list statistics checker
// Watches the byte and statistics channels of the parser. Every byte taken
// by the block is run through a local model of the line parser, each text
// end queues the statistics it should produce, and every statistics item
// that leaves the block is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module ranked_list_stats_checker #(
    parameter int MAX_VOTERS = 128,
    parameter int TOPIC_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    rlfs_in_if   in_ch,
    rlfs_out_if  out_ch,
    output int   mismatch_count,
    output int   stats_pending
);

    import rlfs_pkg::*;

    typedef struct packed {
        logic [QCOUNT_W-1:0] queries;
        logic [VCOUNT_W-1:0] voters;
        logic [VAL_W-1:0]    rank;
    } text_stats_t;

    text_stats_t stats_due[$];

    phase_t              phase;
    bit                  colon_seen;
    logic [TOPIC_BITS-1:0] topic_acc;
    logic [TOPIC_BITS-1:0] topic_prev;
    logic [QCOUNT_W-1:0] query_runs;
    logic [VAL_W-1:0]    tok_voter;
    logic [VAL_W-1:0]    tok_rank;
    logic [4:0]          tok_len;
    logic [7:0]          tok_last;
    bit                  voter_hit [MAX_VOTERS];
    int                  distinct_voters;
    logic [VAL_W-1:0]    top_rank;

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [VAL_W-1:0] push_digit(logic [VAL_W-1:0] acc, logic [7:0] c);
        int unsigned v;
        v = 32'(acc) * 10 + 32'(c) - 32'(CH_ZERO);
        return (v > 65535) ? 16'hFFFF : v[VAL_W-1:0];
    endfunction

    function automatic void clear_token();
        colon_seen = 1'b0;
        tok_voter = '0;
        tok_rank = '0;
        tok_len = '0;
        tok_last = '0;
    endfunction

    function automatic void clear_parser();
        phase = PH_REL;
        topic_acc = '0;
        topic_prev = '0;
        query_runs = '0;
        clear_token();
        foreach (voter_hit[i])
            voter_hit[i] = 1'b0;
        distinct_voters = 0;
        top_rank = '0;
    endfunction

    function automatic void close_token();
        if (tok_len != 0 && tok_last != CH_UPPER_L)
        begin
            if (tok_voter >= 1 && tok_voter <= MAX_VOTERS)
            begin
                if (!voter_hit[tok_voter - 1])
                begin
                    voter_hit[tok_voter - 1] = 1'b1;
                    distinct_voters++;
                end
            end
            if (tok_rank > top_rank)
                top_rank = tok_rank;
        end
        clear_token();
    endfunction

    function automatic void token_byte(logic [7:0] c);
        if (tok_len < 31)
            tok_len++;
        tok_last = c;
        if (c == CH_COLON)
        begin
            if (!colon_seen)
                colon_seen = 1'b1;
            else
                tok_rank = '0;
        end
        else if (is_digit(c))
        begin
            if (colon_seen)
                tok_rank = push_digit(tok_rank, c);
            else
                tok_voter = push_digit(tok_voter, c);
        end
    endfunction

    function automatic void note_query_change();
        if (query_runs != 0 && topic_acc != topic_prev)
        begin
            if (query_runs < QCOUNT_MAX)
                query_runs++;
            topic_prev = topic_acc;
        end
    endfunction

    function automatic void parse_text_byte(logic [7:0] c, logic text_end);
        bit field_gap;
        text_stats_t due;
        field_gap = (c == CH_TAB || c == CH_SPACE);
        if (c == CH_LF)
        begin
            note_query_change();
            clear_token();
            phase = PH_REL;
        end
        else
        begin
            case (phase)
                PH_REL:
                begin
                    if (field_gap)
                    begin
                        phase = PH_QID;
                        topic_acc = '0;
                        colon_seen = 1'b0;
                    end
                end
                PH_QID:
                begin
                    if (field_gap)
                    begin
                        phase = PH_VOT;
                        clear_token();
                        if (query_runs == 0)
                        begin
                            topic_prev = topic_acc;
                            query_runs = 1;
                        end
                    end
                    else if (c == CH_COLON)
                    begin
                        topic_acc = '0;
                        colon_seen = 1'b1;
                    end
                    else if (colon_seen)
                    begin
                        if (is_digit(c))
                            topic_acc = topic_acc * 10 + TOPIC_BITS'(c - CH_ZERO);
                        else
                            colon_seen = 1'b0;
                    end
                end
                PH_VOT:
                begin
                    if (c == CH_HASH)
                    begin
                        close_token();
                        phase = PH_SKIP;
                    end
                    else if (c == CH_SPACE)
                        close_token();
                    else
                        token_byte(c);
                end
                default:
                begin
                end
            endcase
        end
        if (text_end)
        begin
            note_query_change();
            due.queries = query_runs;
            due.voters = (distinct_voters > 255) ? 8'hFF : VCOUNT_W'(distinct_voters);
            due.rank = top_rank;
            stats_due.push_back(due);
            clear_parser();
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        text_stats_t oldest;
        if (!rst_n)
        begin
            clear_parser();
            stats_due.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                parse_text_byte(in_ch.data_byte, in_ch.end_of_input);
            if (out_ch.valid && out_ch.ready)
            begin
                if (stats_due.size() == 0)
                begin
                    $error("Unexpected item: query_count %0d, voter_count %0d, max_rank %0d",
                           out_ch.query_count, out_ch.voter_count, out_ch.max_rank);
                    mismatch_count++;
                end
                else
                begin
                    oldest = stats_due.pop_front();
                    check_field("query_count", 32'(oldest.queries), 32'(out_ch.query_count));
                    check_field("voter_count", 32'(oldest.voters), 32'(out_ch.voter_count));
                    check_field("max_rank", 32'(oldest.rank), 32'(out_ch.max_rank));
                end
            end
        end
        stats_pending = stats_due.size();
    end

endmodule

// ===== verif/tb_ranked_list_file_stats_parser_core.sv =====
// ----------------------------------------------------------------------------
// Ranked-list file statistics parser testbench
// Streams short ranked-list texts into the parser: a few hand-made texts,
// then random texts made of well-formed lines with random content, broken
// and truncated lines, noise bytes, and a long run of tiny texts that wraps
// the voter map epoch. The sender works in bursts and the receiver stalls
// on its own pattern, once for a long stretch. A checker module predicts
// and compares every statistics item.
// ----------------------------------------------------------------------------
module tb_ranked_list_file_stats_parser_core;

    import rlfs_pkg::*;

    localparam int MAX_VOTERS = 128;
    localparam int TOPIC_BITS = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int FIRST_PART_BYTES = 650;
    localparam int TOTAL_BYTES = 1450;
    localparam int EPOCH_TEXTS = 260;
    localparam int HOLD_AT_RESULT = 10;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    rlfs_in_if  in_ch ();
    rlfs_out_if out_ch ();

    int mismatch_count;
    int stats_pending;
    int burst_left;
    int bytes_sent;
    int cycle_count;
    logic [7:0] text_buf[$];

    always #1 clk = ~clk;

    ranked_list_file_stats_parser_core #(
        .MAX_VOTERS(MAX_VOTERS),
        .TOPIC_BITS(TOPIC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    ranked_list_stats_checker #(
        .MAX_VOTERS(MAX_VOTERS),
        .TOPIC_BITS(TOPIC_BITS)
    ) stats_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .mismatch_count(mismatch_count),
        .stats_pending(stats_pending)
    );

    function automatic logic [7:0] pick_char();
        string char_set;
        char_set = " \t:#L\n0123456789x\r";
        return char_set[$urandom_range(0, char_set.len() - 1)];
    endfunction

    function automatic longint unsigned pick_value();
        case ($urandom_range(0, 9))
            0: return 0;
            1, 2, 3, 4: return $urandom_range(1, 24);
            5: return $urandom_range(126, 130);
            6: return $urandom_range(65530, 65540);
            7: return $urandom_range(0, 2000);
            8: return {$urandom, $urandom};
            default: return 1;
        endcase
    endfunction

    function automatic longint unsigned pick_topic();
        case ($urandom_range(0, 5))
            0: return 64'd4294967296 + $urandom_range(0, 3);
            1: return $urandom;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    function automatic void add_num(longint unsigned n);
        add_str($sformatf("%0d", n));
    endfunction

    function automatic void add_gap();
        text_buf.push_back(($urandom_range(0, 2) == 0) ? CH_TAB : CH_SPACE);
    endfunction

    function automatic void add_tiny();
        repeat ($urandom_range(1, 3))
            text_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                           : pick_char());
    endfunction

    function automatic void add_token();
        case ($urandom_range(0, 11))
            6:
            begin
                add_num(pick_value());
                add_str(":NULL");
            end
            7: add_num(pick_value());
            8:
            begin
                add_num(pick_value());
                add_str(":");
                add_num(pick_value());
                add_str(":");
                add_num(pick_value());
            end
            9:
            begin
                repeat ($urandom_range(1, 4))
                    text_buf.push_back(pick_char());
            end
            10:
            begin
            end
            11:
            begin
                add_str(":");
                add_num(pick_value());
            end
            default:
            begin
                add_num(pick_value());
                add_str(":");
                add_num(pick_value());
            end
        endcase
    endfunction

    function automatic void add_line(longint unsigned topic);
        int start;
        int cut;
        int tokens;
        start = text_buf.size();
        case ($urandom_range(0, 3))
            0:
            begin
            end
            1: add_num($urandom_range(0, 4));
            2: add_str("-1");
            default: add_num(pick_value());
        endcase
        add_gap();
        case ($urandom_range(0, 7))
            0: add_str("qid");
            1:
            begin
                add_str("a:b:");
                add_num(topic);
            end
            2:
            begin
                add_str("qid:");
                add_num(topic);
                text_buf.push_back(pick_char());
                add_num(pick_value());
            end
            default:
            begin
                add_str("qid:");
                add_num(topic);
            end
        endcase
        add_gap();
        tokens = $urandom_range(0, 4);
        for (int i = 0; i < tokens; i++)
        begin
            add_token();
            if (i < tokens - 1)
                add_str(($urandom_range(0, 5) == 0) ? "  " : " ");
        end
        if ($urandom_range(0, 5) != 0)
        begin
            add_str("#");
            repeat ($urandom_range(0, 3))
                text_buf.push_back(pick_char());
        end
        if ($urandom_range(0, 5) == 0)
            add_str("\r");
        if ($urandom_range(0, 7) == 0)
        begin
            cut = $urandom_range(start, text_buf.size() - 1);
            while (text_buf.size() > cut)
                void'(text_buf.pop_back());
        end
        add_str("\n");
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= value;
        in_ch.end_of_input <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic put_text();
        if (text_buf.size() == 0)
            text_buf.push_back(pick_char());
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (stats_pending != 0)
            @(posedge clk);
    endtask

    task automatic send_random_text();
        longint unsigned topic;
        int kind;
        int cut;
        topic = pick_topic();
        kind = $urandom_range(0, 9);
        if (kind == 9)
            add_tiny();
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 2) == 0)
                    topic = pick_topic();
                add_line(topic);
            end
        end
        if (kind < 3 && text_buf.size() > 1)
            void'(text_buf.pop_back());
        else if (kind < 5)
        begin
            cut = $urandom_range(1, text_buf.size());
            while (text_buf.size() > cut)
                void'(text_buf.pop_back());
        end
        else if (kind == 5)
        begin
            repeat (2)
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        put_text();
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int taken;
        int span;
        int mode;
        int tick;
        bit held;
        taken = 0;
        span = 0;
        mode = 0;
        tick = 0;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                taken++;
            if (!held && taken == HOLD_AT_RESULT)
            begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 4);
                span = $urandom_range(5, 60);
            end
            span--;
            tick++;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                2: out_ch.ready <= (tick % 4 == 0);
                3: out_ch.ready <= ($urandom_range(0, 9) != 0);
                default: out_ch.ready <= 1'b0;
            endcase
        end
    end

    initial
    begin
        burst_left = 0;
        bytes_sent = 0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.end_of_input <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_str("\t:4 5:99999  2L 0:8#\n");
        put_text();
        add_str(" :9 7:");
        put_text();
        text_buf.push_back(8'hFF);
        put_text();
        text_buf.push_back(8'h00);
        put_text();
        drain();

        while (bytes_sent < FIRST_PART_BYTES)
            send_random_text();
        drain();

        for (int i = 0; i < EPOCH_TEXTS; i++)
        begin
            if (i % 8 == 0)
            begin
                add_str(" :");
                add_num($urandom_range(0, 3));
                add_str(" ");
                add_num($urandom_range(1, 10));
                add_str(":");
                add_num($urandom_range(0, 99));
                add_str("#");
            end
            else
                add_tiny();
            put_text();
        end

        while (bytes_sent < TOTAL_BYTES)
            send_random_text();
        drain();
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && stats_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
